// ===== rtl/core/light_therapy_session_controller_macros.svh =====
// ----------------------------------------------------------------------------
// Light therapy session controller assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef LIGHT_THERAPY_SESSION_CONTROLLER_MACROS_SVH
`define LIGHT_THERAPY_SESSION_CONTROLLER_MACROS_SVH

// Same-cycle implication.
`define LTSC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LTSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ltsc_pkg.sv =====
// ----------------------------------------------------------------------------
// Light therapy session controller package
// Event codes, register indexes, reset values, payload types and helpers.
// ----------------------------------------------------------------------------
package ltsc_pkg;

  // Event codes
  localparam logic [2:0] OP_SHORT_KEY = 3'd0;
  localparam logic [2:0] OP_LONG_KEY  = 3'd1;
  localparam logic [2:0] OP_TICK      = 3'd2;
  localparam logic [2:0] OP_LINK      = 3'd3;
  localparam logic [2:0] OP_TEMP      = 3'd4;

  // Beep codes
  localparam logic [1:0] BEEP_NONE     = 2'd0;
  localparam logic [1:0] BEEP_PROGRESS = 2'd1;
  localparam logic [1:0] BEEP_PHASE    = 2'd2;
  localparam logic [1:0] BEEP_END      = 2'd3;

  // Mode codes
  localparam logic [1:0] MODE_OFF      = 2'd0;
  localparam logic [1:0] MODE_RED      = 2'd1;
  localparam logic [1:0] MODE_BLUE     = 2'd2;
  localparam logic [1:0] MODE_RED_BLUE = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] CFG_THERMAL_LIMIT   = 3'd0;
  localparam logic [2:0] CFG_BLUE_SECONDS    = 3'd1;
  localparam logic [2:0] CFG_RED_SECONDS     = 3'd2;
  localparam logic [2:0] CFG_IDLE_LIMIT      = 3'd3;
  localparam logic [2:0] CFG_WEAR_ON_FRAMES  = 3'd4;
  localparam logic [2:0] CFG_WEAR_OFF_FRAMES = 3'd5;
  localparam logic [2:0] CFG_LINK_FRAMES     = 3'd6;
  localparam logic [2:0] CFG_REQUIRE_LINK    = 3'd7;

  // Configuration reset values
  localparam logic [11:0] RST_THERMAL_LIMIT   = 12'd1500;
  localparam logic [11:0] RST_BLUE_SECONDS    = 12'd600;
  localparam logic [11:0] RST_RED_SECONDS     = 12'd1200;
  localparam logic [11:0] RST_IDLE_LIMIT      = 12'd600;
  localparam logic [3:0]  RST_WEAR_ON_FRAMES  = 4'd10;
  localparam logic [3:0]  RST_WEAR_OFF_FRAMES = 4'd2;
  localparam logic [3:0]  RST_LINK_FRAMES     = 4'd3;
  localparam logic        RST_REQUIRE_LINK    = 1'b1;

  localparam logic [11:0] SECS_MAX   = 12'hFFF;
  localparam int          BEEP_STEP  = 300;
  localparam int          BEEP_MULTS = 4095 / BEEP_STEP;

  typedef struct packed {
    logic [2:0]  opcode;
    logic        link_seen;
    logic [11:0] temp_a;
    logic [11:0] temp_b;
    logic        battery_not_empty;
  } in_item_t;

  typedef struct packed {
    logic        powered;
    logic [1:0]  mode;
    logic        treating;
    logic        paused;
    logic        phase_red;
    logic [11:0] seconds_left;
    logic        worn;
    logic        thermal_error;
    logic        red_drive;
    logic        blue_drive;
    logic [1:0]  beep;
  } out_item_t;

  // True when secs is a nonzero multiple of the progress step.
  function automatic logic is_beep_step(input logic [11:0] secs);
    logic hit;
    hit = 1'b0;
    for (int k = 1; k <= BEEP_MULTS; k++) begin
      if (secs == 12'(BEEP_STEP * k)) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

// ===== rtl/core/light_therapy_session_controller.sv =====
// ----------------------------------------------------------------------------
// Light therapy session controller
// Event-driven power, mode, wear, thermal and phase timer control.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one event per transfer (key, tick, link sample, temperature).
//   out_* : one status item per event, in event order.
//   cfg_* : register writes, taken at any edge with cfg_we high; write only
//           while no event is in flight.
// Order: an accepted event is captured in the input register; its status is
//   then registered in the output register, which raises out_valid, and the
//   status waits there until out_ready takes it.
// Throughput: one event per cycle while the output is not stalled. The
//   session state update is a single combinational pass from the input
//   register into the state and output registers.
// Stall: while out_valid is high and out_ready low, the output holds; one
//   more event waits in the input register, then in_ready drops.
// Reset: synchronous, active low. The unit powers up off, all session state
//   cleared and the registers at their default values.
// ----------------------------------------------------------------------------
module light_therapy_session_controller (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ltsc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ltsc_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [11:0]         cfg_wdata
);

  // Configuration registers
  logic [11:0] thermal_limit_r, blue_seconds_r, red_seconds_r, idle_limit_r;
  logic [3:0]  wear_on_frames_r, wear_off_frames_r, link_frames_r;
  logic        require_link_r;

  // Pipeline
  ltsc_pkg::in_item_t  in_q_r;
  logic                in_q_valid_r;
  ltsc_pkg::out_item_t out_r, out_nxt;
  logic                out_valid_r;
  logic                advance;

  // Session state
  logic        power_r, power_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic        treat_r, treat_nxt;
  logic        pause_r, pause_nxt;
  logic        phase_r, phase_nxt;
  logic [11:0] secs_r, secs_nxt;
  logic [3:0]  on_cnt_r, on_cnt_nxt;
  logic [3:0]  off_cnt_r, off_cnt_nxt;
  logic [3:0]  link_cnt_r, link_cnt_nxt;
  logic        link_ok_r, link_ok_nxt;
  logic        wear_r, wear_nxt;
  logic        heat_r, heat_nxt;
  logic [11:0] idle_r, idle_nxt;
  logic        bat_r, bat_nxt;
  logic [1:0]  beep_nxt;
  logic        drive;

  assign advance   = in_q_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_q_valid_r || !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thermal_limit_r   <= ltsc_pkg::RST_THERMAL_LIMIT;
      blue_seconds_r    <= ltsc_pkg::RST_BLUE_SECONDS;
      red_seconds_r     <= ltsc_pkg::RST_RED_SECONDS;
      idle_limit_r      <= ltsc_pkg::RST_IDLE_LIMIT;
      wear_on_frames_r  <= ltsc_pkg::RST_WEAR_ON_FRAMES;
      wear_off_frames_r <= ltsc_pkg::RST_WEAR_OFF_FRAMES;
      link_frames_r     <= ltsc_pkg::RST_LINK_FRAMES;
      require_link_r    <= ltsc_pkg::RST_REQUIRE_LINK;
    end else if (cfg_we) begin
      case (cfg_index)
        ltsc_pkg::CFG_THERMAL_LIMIT:   thermal_limit_r   <= cfg_wdata;
        ltsc_pkg::CFG_BLUE_SECONDS:    blue_seconds_r    <= cfg_wdata;
        ltsc_pkg::CFG_RED_SECONDS:     red_seconds_r     <= cfg_wdata;
        ltsc_pkg::CFG_IDLE_LIMIT:      idle_limit_r      <= cfg_wdata;
        ltsc_pkg::CFG_WEAR_ON_FRAMES:  wear_on_frames_r  <= cfg_wdata[3:0];
        ltsc_pkg::CFG_WEAR_OFF_FRAMES: wear_off_frames_r <= cfg_wdata[3:0];
        ltsc_pkg::CFG_LINK_FRAMES:     link_frames_r     <= cfg_wdata[3:0];
        ltsc_pkg::CFG_REQUIRE_LINK:    require_link_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_q_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_q_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q_r <= in_data;
    end
  end

  // Event evaluation, in the fixed order: wear, thermal, pause, power-off,
  // key or overheat stop, tick.
  always_comb begin
    power_nxt    = power_r;
    mode_nxt     = mode_r;
    treat_nxt    = treat_r;
    pause_nxt    = pause_r;
    phase_nxt    = phase_r;
    secs_nxt     = secs_r;
    on_cnt_nxt   = on_cnt_r;
    off_cnt_nxt  = off_cnt_r;
    link_cnt_nxt = link_cnt_r;
    link_ok_nxt  = link_ok_r;
    wear_nxt     = wear_r;
    heat_nxt     = heat_r;
    idle_nxt     = idle_r;
    bat_nxt      = bat_r;
    beep_nxt     = ltsc_pkg::BEEP_NONE;

    if (!power_r) begin
      if (in_q_r.opcode == ltsc_pkg::OP_LONG_KEY && !heat_r) power_nxt = 1'b1;
    end else begin
      if (in_q_r.opcode == ltsc_pkg::OP_LINK) begin
        if (in_q_r.link_seen) begin
          if (link_cnt_nxt < link_frames_r) link_cnt_nxt = link_cnt_nxt + 4'd1;
          if (link_cnt_nxt >= link_frames_r) link_ok_nxt = 1'b1;
          on_cnt_nxt = 4'd0;
          if (off_cnt_nxt < wear_off_frames_r) off_cnt_nxt = off_cnt_nxt + 4'd1;
          if (off_cnt_nxt >= wear_off_frames_r) wear_nxt = 1'b0;
        end else begin
          off_cnt_nxt  = 4'd0;
          link_cnt_nxt = 4'd0;
          if (on_cnt_nxt < wear_on_frames_r) on_cnt_nxt = on_cnt_nxt + 4'd1;
          // wear-on stays blocked until the link is confirmed, if required
          if (!(require_link_r && !link_ok_nxt) && on_cnt_nxt >= wear_on_frames_r) begin
            wear_nxt = 1'b1;
          end
        end
      end

      if (in_q_r.opcode == ltsc_pkg::OP_TEMP) begin
        if (!heat_nxt && (in_q_r.temp_a < thermal_limit_r ||
                          in_q_r.temp_b < thermal_limit_r)) begin
          heat_nxt = 1'b1;
        end else if (heat_nxt && in_q_r.temp_a > thermal_limit_r &&
                     in_q_r.temp_b > thermal_limit_r) begin
          heat_nxt = 1'b0;
        end
      end

      if (treat_nxt && !pause_nxt && !wear_nxt) begin
        pause_nxt = 1'b1;
      end else if (treat_nxt && pause_nxt && wear_nxt) begin
        pause_nxt = 1'b0;
      end

      if (in_q_r.opcode == ltsc_pkg::OP_LONG_KEY || idle_r >= idle_limit_r) begin
        // power down: clear all but the link count and battery bit
        power_nxt   = 1'b0;
        mode_nxt    = ltsc_pkg::MODE_OFF;
        treat_nxt   = 1'b0;
        pause_nxt   = 1'b0;
        phase_nxt   = 1'b0;
        secs_nxt    = 12'd0;
        on_cnt_nxt  = 4'd0;
        off_cnt_nxt = 4'd0;
        link_ok_nxt = 1'b0;
        wear_nxt    = 1'b0;
        heat_nxt    = 1'b0;
        idle_nxt    = 12'd0;
      end else begin
        if (in_q_r.opcode == ltsc_pkg::OP_SHORT_KEY) begin
          mode_nxt = mode_nxt + 2'd1;
          if (mode_nxt == ltsc_pkg::MODE_OFF) begin
            treat_nxt = 1'b0;
            secs_nxt  = 12'd0;
          end else begin
            treat_nxt = 1'b1;
            pause_nxt = 1'b0;
            if (mode_nxt == ltsc_pkg::MODE_RED) begin
              phase_nxt = 1'b1;
              secs_nxt  = red_seconds_r;
            end else begin
              phase_nxt = 1'b0;
              secs_nxt  = blue_seconds_r;
            end
          end
        end else if (heat_nxt) begin
          treat_nxt = 1'b0;
          secs_nxt  = 12'd0;
          mode_nxt  = ltsc_pkg::MODE_OFF;
        end

        if (in_q_r.opcode == ltsc_pkg::OP_TICK) begin
          bat_nxt = in_q_r.battery_not_empty;
          if (treat_nxt && !pause_nxt && mode_nxt != ltsc_pkg::MODE_OFF &&
              !heat_nxt && bat_nxt) begin
            idle_nxt = 12'd0;
            if (secs_nxt != 12'd0) secs_nxt = secs_nxt - 12'd1;
            if (secs_nxt != 12'd0) begin
              beep_nxt = ltsc_pkg::is_beep_step(secs_nxt) ?
                         ltsc_pkg::BEEP_PROGRESS : ltsc_pkg::BEEP_NONE;
            end else if (mode_nxt == ltsc_pkg::MODE_RED_BLUE && !phase_nxt) begin
              // blue phase done: move on to red
              phase_nxt = 1'b1;
              secs_nxt  = red_seconds_r;
              beep_nxt  = ltsc_pkg::BEEP_PHASE;
            end else begin
              treat_nxt = 1'b0;
              secs_nxt  = 12'd0;
              mode_nxt  = ltsc_pkg::MODE_OFF;
              beep_nxt  = ltsc_pkg::BEEP_END;
            end
          end else if (idle_nxt != ltsc_pkg::SECS_MAX) begin
            idle_nxt = idle_nxt + 12'd1;
          end
        end
      end
    end

    drive = power_nxt && treat_nxt && !pause_nxt && mode_nxt != ltsc_pkg::MODE_OFF &&
            !heat_nxt && bat_nxt;

    out_nxt.powered       = power_nxt;
    out_nxt.mode          = mode_nxt;
    out_nxt.treating      = treat_nxt;
    out_nxt.paused        = pause_nxt;
    out_nxt.phase_red     = phase_nxt;
    out_nxt.seconds_left  = secs_nxt;
    out_nxt.worn          = wear_nxt;
    out_nxt.thermal_error = heat_nxt;
    out_nxt.red_drive     = drive && phase_nxt;
    out_nxt.blue_drive    = drive && !phase_nxt;
    out_nxt.beep          = beep_nxt;
  end

  // State and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_r    <= 1'b0;
      mode_r     <= ltsc_pkg::MODE_OFF;
      treat_r    <= 1'b0;
      pause_r    <= 1'b0;
      phase_r    <= 1'b0;
      secs_r     <= 12'd0;
      on_cnt_r   <= 4'd0;
      off_cnt_r  <= 4'd0;
      link_cnt_r <= 4'd0;
      link_ok_r  <= 1'b0;
      wear_r     <= 1'b0;
      heat_r     <= 1'b0;
      idle_r     <= 12'd0;
      bat_r      <= 1'b0;
    end else if (advance) begin
      power_r    <= power_nxt;
      mode_r     <= mode_nxt;
      treat_r    <= treat_nxt;
      pause_r    <= pause_nxt;
      phase_r    <= phase_nxt;
      secs_r     <= secs_nxt;
      on_cnt_r   <= on_cnt_nxt;
      off_cnt_r  <= off_cnt_nxt;
      link_cnt_r <= link_cnt_nxt;
      link_ok_r  <= link_ok_nxt;
      wear_r     <= wear_nxt;
      heat_r     <= heat_nxt;
      idle_r     <= idle_nxt;
      bat_r      <= bat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= out_nxt;
    end
  end

endmodule

// ===== rtl/core/ltsc_checker.sv =====
// ----------------------------------------------------------------------------
// Light therapy session controller port checker
// Watches the result channel for handshake and status consistency.
// ----------------------------------------------------------------------------
`include "light_therapy_session_controller_macros.svh"

module ltsc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input ltsc_pkg::out_item_t out_data
);

  // Hold a stalled result.
  `LTSC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed or dropped")

  // Powered off means an empty session and dark emitters.
  `LTSC_ASSERT_SAME(a_off_idle, clk, rst_n, out_valid && !out_data.powered, out_data.mode == ltsc_pkg::MODE_OFF && !out_data.treating && !out_data.red_drive && !out_data.blue_drive && out_data.beep == ltsc_pkg::BEEP_NONE, "powered-off status not cleared")

  // Light only in an active, unpaused, cool session, on the current phase.
  `LTSC_ASSERT_SAME(a_drive_ok, clk, rst_n, out_valid && (out_data.red_drive || out_data.blue_drive), out_data.treating && !out_data.paused && !out_data.thermal_error && out_data.mode != ltsc_pkg::MODE_OFF && (out_data.red_drive == out_data.phase_red) && (out_data.blue_drive != out_data.phase_red), "emitter driven outside an active session")

  // A session-end beep leaves the session stopped.
  `LTSC_ASSERT_SAME(a_end_stop, clk, rst_n, out_valid && out_data.beep == ltsc_pkg::BEEP_END, !out_data.treating && out_data.mode == ltsc_pkg::MODE_OFF && out_data.seconds_left == 12'd0, "session end beep with session still active")

endmodule

bind light_therapy_session_controller ltsc_checker u_ltsc_checker (.*);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Light therapy session controller testbench
// Drives key, tick, link and temperature events through the valid/ready
// input, predicts every status item in a scoreboard and compares it field by
// field. Registers are reprogrammed between runs while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  import ltsc_pkg::*;

  localparam logic [2:0] OP_RSVD_5 = 3'd5;
  localparam logic [2:0] OP_RSVD_6 = 3'd6;
  localparam logic [2:0] OP_RSVD_7 = 3'd7;
  localparam int         RUNS      = 8;
  localparam int         RUN_ITEMS = 175;
  localparam int         HOLD_OFF  = 80;

  class session_status_board;
    logic [11:0] temp_trip, blue_len, red_len, idle_cap;
    logic [3:0]  wear_on_need, wear_off_need, link_need;
    logic        link_gate;
    logic        powered_on, treating, paused, red_phase, worn, hot, link_ok, bat_seen;
    logic [1:0]  mode;
    logic [11:0] secs_left, idle_secs;
    logic [3:0]  dark_cnt, lit_cnt, carrier_cnt;
    out_item_t   expected_status[$];
    int          errors, checked, power_offs, trips;
    int          tones[4];

    function new();
      temp_trip     = RST_THERMAL_LIMIT;
      blue_len      = RST_BLUE_SECONDS;
      red_len       = RST_RED_SECONDS;
      idle_cap      = RST_IDLE_LIMIT;
      wear_on_need  = RST_WEAR_ON_FRAMES;
      wear_off_need = RST_WEAR_OFF_FRAMES;
      link_need     = RST_LINK_FRAMES;
      link_gate     = RST_REQUIRE_LINK;
      shut_down();
      carrier_cnt = '0;
      bat_seen    = 1'b0;
      errors      = 0;
      checked     = 0;
      power_offs  = 0;
      trips       = 0;
      foreach (tones[i]) tones[i] = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [11:0] val);
      case (idx)
        CFG_THERMAL_LIMIT:   temp_trip = val;
        CFG_BLUE_SECONDS:    blue_len = val;
        CFG_RED_SECONDS:     red_len = val;
        CFG_IDLE_LIMIT:      idle_cap = val;
        CFG_WEAR_ON_FRAMES:  wear_on_need = val[3:0];
        CFG_WEAR_OFF_FRAMES: wear_off_need = val[3:0];
        CFG_LINK_FRAMES:     link_need = val[3:0];
        CFG_REQUIRE_LINK:    link_gate = val[0];
        default: ;
      endcase
    endfunction

    // Link count and battery bit survive power-off.
    function void shut_down();
      powered_on = 1'b0;
      mode       = MODE_OFF;
      treating   = 1'b0;
      paused     = 1'b0;
      red_phase  = 1'b0;
      secs_left  = '0;
      dark_cnt   = '0;
      lit_cnt    = '0;
      link_ok    = 1'b0;
      worn       = 1'b0;
      hot        = 1'b0;
      idle_secs  = '0;
    endfunction

    function void end_session();
      treating  = 1'b0;
      secs_left = '0;
      mode      = MODE_OFF;
    endfunction

    function void start_session();
      treating = 1'b1;
      paused   = 1'b0;
      red_phase = (mode == MODE_RED);
      secs_left = (mode == MODE_RED) ? red_len : blue_len;
    endfunction

    function logic emitting();
      return powered_on && treating && !paused && mode != MODE_OFF && !hot && bat_seen;
    endfunction

    function void sample_link(logic seen);
      if (seen) begin
        if (carrier_cnt < link_need) carrier_cnt++;
        if (carrier_cnt >= link_need) link_ok = 1'b1;
        dark_cnt = '0;
        if (lit_cnt < wear_off_need) lit_cnt++;
        if (lit_cnt >= wear_off_need) worn = 1'b0;
      end else begin
        lit_cnt     = '0;
        carrier_cnt = '0;
        if (dark_cnt < wear_on_need) dark_cnt++;
        // hold wear-on back until the link is confirmed, when gated
        if (!(link_gate && !link_ok) && dark_cnt >= wear_on_need) worn = 1'b1;
      end
    endfunction

    function logic [1:0] count_down();
      if (secs_left != 0) secs_left--;
      if (secs_left != 0)
        return (secs_left % 12'(BEEP_STEP) == 12'd0) ? BEEP_PROGRESS : BEEP_NONE;
      if (mode == MODE_RED_BLUE && !red_phase) begin
        red_phase = 1'b1;
        secs_left = red_len;
        return BEEP_PHASE;
      end
      end_session();
      return BEEP_END;
    endfunction

    function void note_event(in_item_t ev);
      out_item_t  st;
      logic [1:0] tone;
      logic       lit;
      tone = BEEP_NONE;
      if (!powered_on) begin
        if (ev.opcode == OP_LONG_KEY && !hot) powered_on = 1'b1;
      end else begin
        if (ev.opcode == OP_LINK) sample_link(ev.link_seen);
        if (ev.opcode == OP_TEMP) begin
          if (!hot && (ev.temp_a < temp_trip || ev.temp_b < temp_trip)) begin
            hot = 1'b1;
            trips++;
          end else if (hot && ev.temp_a > temp_trip && ev.temp_b > temp_trip) begin
            hot = 1'b0;
          end
        end
        if (treating && !paused && !worn) paused = 1'b1;
        else if (treating && paused && worn) paused = 1'b0;

        if (ev.opcode == OP_LONG_KEY || idle_secs >= idle_cap) begin
          shut_down();
          power_offs++;
        end else begin
          if (ev.opcode == OP_SHORT_KEY) begin
            mode = mode + 2'd1;
            if (mode == MODE_OFF) end_session();
            else start_session();
          end else if (hot) begin
            end_session();
          end
          if (ev.opcode == OP_TICK) begin
            bat_seen = ev.battery_not_empty;
            if (emitting()) begin
              idle_secs = '0;
              tone = count_down();
            end else if (idle_secs != SECS_MAX) begin
              idle_secs++;
            end
          end
        end
      end
      lit = emitting();
      st.powered       = powered_on;
      st.mode          = mode;
      st.treating      = treating;
      st.paused        = paused;
      st.phase_red     = red_phase;
      st.seconds_left  = secs_left;
      st.worn          = worn;
      st.thermal_error = hot;
      st.red_drive     = lit && red_phase;
      st.blue_drive    = lit && !red_phase;
      st.beep          = tone;
      tones[tone]++;
      expected_status.push_back(st);
    endfunction

    function int pending();
      return expected_status.size();
    endfunction

    task report(string what, logic [11:0] want, logic [11:0] got);
      errors++;
      if (errors <= 40)
        $display("tb: status %0d %s: expected %0h, got %0h", checked, what, want, got);
    endtask

    task check_status(out_item_t got);
      out_item_t want;
      checked++;
      if (expected_status.size() == 0) begin
        report("arrived with nothing pending", '0, got.seconds_left);
        return;
      end
      want = expected_status.pop_front();
      if (got.powered !== want.powered)
        report("powered", 12'(want.powered), 12'(got.powered));
      if (got.mode !== want.mode) report("mode", 12'(want.mode), 12'(got.mode));
      if (got.treating !== want.treating)
        report("treating", 12'(want.treating), 12'(got.treating));
      if (got.paused !== want.paused)
        report("paused", 12'(want.paused), 12'(got.paused));
      if (got.phase_red !== want.phase_red)
        report("phase_red", 12'(want.phase_red), 12'(got.phase_red));
      if (got.seconds_left !== want.seconds_left)
        report("seconds_left", want.seconds_left, got.seconds_left);
      if (got.worn !== want.worn) report("worn", 12'(want.worn), 12'(got.worn));
      if (got.thermal_error !== want.thermal_error)
        report("thermal_error", 12'(want.thermal_error), 12'(got.thermal_error));
      if (got.red_drive !== want.red_drive)
        report("red_drive", 12'(want.red_drive), 12'(got.red_drive));
      if (got.blue_drive !== want.blue_drive)
        report("blue_drive", 12'(want.blue_drive), 12'(got.blue_drive));
      if (got.beep !== want.beep) report("beep", 12'(want.beep), 12'(got.beep));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [11:0] cfg_wdata;

  session_status_board sb = new();
  logic [11:0] reg_plan [8];
  logic        calm = 1'b0;
  logic        squeeze_req = 1'b0;
  int          run_sent = 0;
  int          events_sent = 0;
  int          settings = 0;
  int          squeezes = 0;

  light_therapy_session_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_status(out_data);
  end

  // Result side: random stalls, plus long hold-offs so the input backs up.
  initial begin
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
        squeezes++;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 11);
      end
    end
  end

  function automatic in_item_t shaped(logic [2:0] op);
    in_item_t ev;
    ev.opcode            = op;
    ev.link_seen         = 1'($urandom_range(0, 1));
    ev.temp_a            = 12'($urandom_range(0, 4095));
    ev.temp_b            = 12'($urandom_range(0, 4095));
    ev.battery_not_empty = 1'($urandom_range(0, 1));
    return ev;
  endfunction

  function automatic logic [11:0] cool();
    if (sb.temp_trip == SECS_MAX) return 12'($urandom_range(0, 4095));
    return 12'($urandom_range(int'(sb.temp_trip) + 1, 4095));
  endfunction

  task automatic send(in_item_t ev);
    while (!calm && $urandom_range(0, 99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    run_sent++;
    events_sent++;
    sb.note_event(ev);
  endtask

  task automatic send_op(logic [2:0] op);
    send(shaped(op));
  endtask

  task automatic send_link(logic seen);
    in_item_t ev;
    ev = shaped(OP_LINK);
    ev.link_seen = seen;
    send(ev);
  endtask

  task automatic send_temp(logic [11:0] a, logic [11:0] b);
    in_item_t ev;
    ev = shaped(OP_TEMP);
    ev.temp_a = a;
    ev.temp_b = b;
    send(ev);
  endtask

  task automatic send_tick(logic bat);
    in_item_t ev;
    ev = shaped(OP_TICK);
    ev.battery_not_empty = bat;
    send(ev);
  endtask

  // Power on, get worn, cool down, pick a mode and run the timer.
  task automatic run_session();
    int n;
    if (!sb.powered_on) send_op(OP_LONG_KEY);
    if (!sb.worn) begin
      repeat (int'(sb.link_need) + 1) send_link(1'b1);
      repeat (int'(sb.wear_on_need) + 1) send_link(1'b0);
    end
    if ($urandom_range(0, 3) != 0) send_temp(cool(), cool());
    repeat ($urandom_range(1, 3)) send_op(OP_SHORT_KEY);
    if (sb.mode == MODE_OFF) send_op(OP_SHORT_KEY);
    n = $urandom_range(2, 40);
    repeat (n) begin
      case ($urandom_range(0, 19))
        0: send_link($urandom_range(0, 5) == 0);
        1: send_temp(cool(), 12'($urandom_range(0, 4095)));
        2: send_op(OP_SHORT_KEY);
        default: send_tick($urandom_range(0, 15) != 0);
      endcase
    end
  endtask

  task automatic load_regs();
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      cfg_wdata <= reg_plan[3'(i)];
      @(posedge clk);
      sb.set_reg(3'(i), reg_plan[3'(i)]);
    end
    cfg_we <= 1'b0;
    settings++;
  endtask

  // Drop valid and let every pending status come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_THERMAL_LIMIT;
    cfg_wdata <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset register values: events while off, thermal trip boundaries.
    send_tick(1'b1);
    send_op(OP_SHORT_KEY);
    send_op(OP_RSVD_5);
    send_op(OP_LONG_KEY);
    send_temp(12'd1500, 12'hFFF);
    send_temp(12'hFFF, 12'd0);
    send_op(OP_SHORT_KEY);
    send_temp(12'd1500, 12'd1501);
    send_temp(12'd1501, 12'hFFF);
    send_op(OP_RSVD_7);
    send_op(OP_LONG_KEY);
    settle();

    // Zero frame counts, short phases: link gate, pause, phase change.
    reg_plan[CFG_THERMAL_LIMIT]   = 12'd2048;
    reg_plan[CFG_BLUE_SECONDS]    = 12'd2;
    reg_plan[CFG_RED_SECONDS]     = 12'd3;
    reg_plan[CFG_IDLE_LIMIT]      = 12'd4;
    reg_plan[CFG_WEAR_ON_FRAMES]  = 12'd0;
    reg_plan[CFG_WEAR_OFF_FRAMES] = 12'd1;
    reg_plan[CFG_LINK_FRAMES]     = 12'd0;
    reg_plan[CFG_REQUIRE_LINK]    = 12'd1;
    load_regs();
    send_op(OP_LONG_KEY);
    send_link(1'b0);
    send_link(1'b1);
    send_link(1'b0);
    send_op(OP_SHORT_KEY);
    send_tick(1'b0);
    send_tick(1'b1);
    send_op(OP_SHORT_KEY);
    send_op(OP_SHORT_KEY);
    send_tick(1'b1);
    send_tick(1'b1);
    send_link(1'b1);
    send_tick(1'b1);
    send_link(1'b0);
    send_tick(1'b1);
    send_op(OP_RSVD_6);
    send_op(OP_LONG_KEY);
    settle();

    for (int run = 0; run < RUNS; run++) begin
      case (run)
        0: begin
          reg_plan[CFG_THERMAL_LIMIT]   = 12'd0;
          reg_plan[CFG_BLUE_SECONDS]    = 12'd1;
          reg_plan[CFG_RED_SECONDS]     = 12'd1;
          reg_plan[CFG_IDLE_LIMIT]      = 12'd1;
          reg_plan[CFG_WEAR_ON_FRAMES]  = 12'd15;
          reg_plan[CFG_WEAR_OFF_FRAMES] = 12'd15;
          reg_plan[CFG_LINK_FRAMES]     = 12'd15;
          reg_plan[CFG_REQUIRE_LINK]    = 12'd0;
        end
        1: begin
          reg_plan[CFG_THERMAL_LIMIT]   = 12'hFFF;
          reg_plan[CFG_BLUE_SECONDS]    = 12'hFFF;
          reg_plan[CFG_RED_SECONDS]     = 12'hFFF;
          reg_plan[CFG_IDLE_LIMIT]      = 12'hFFF;
          reg_plan[CFG_WEAR_ON_FRAMES]  = 12'd1;
          reg_plan[CFG_WEAR_OFF_FRAMES] = 12'd1;
          reg_plan[CFG_LINK_FRAMES]     = 12'd1;
          reg_plan[CFG_REQUIRE_LINK]    = 12'd1;
        end
        3: begin
          // long phases that cross the progress step
          reg_plan[CFG_THERMAL_LIMIT]   = 12'($urandom_range(500, 2500));
          reg_plan[CFG_BLUE_SECONDS]    = 12'($urandom_range(301, 310));
          reg_plan[CFG_RED_SECONDS]     = 12'($urandom_range(300, 305));
          reg_plan[CFG_IDLE_LIMIT]      = 12'($urandom_range(30, 100));
          reg_plan[CFG_WEAR_ON_FRAMES]  = 12'($urandom_range(1, 4));
          reg_plan[CFG_WEAR_OFF_FRAMES] = 12'($urandom_range(1, 4));
          reg_plan[CFG_LINK_FRAMES]     = 12'($urandom_range(1, 4));
          reg_plan[CFG_REQUIRE_LINK]    = 12'd1;
        end
        4: begin
          reg_plan[CFG_THERMAL_LIMIT]   = 12'($urandom_range(200, 3000));
          reg_plan[CFG_BLUE_SECONDS]    = 12'($urandom_range(2, 20));
          reg_plan[CFG_RED_SECONDS]     = 12'($urandom_range(2, 20));
          reg_plan[CFG_IDLE_LIMIT]      = 12'($urandom_range(10, 60));
          reg_plan[CFG_WEAR_ON_FRAMES]  = 12'd0;
          reg_plan[CFG_WEAR_OFF_FRAMES] = 12'd0;
          reg_plan[CFG_LINK_FRAMES]     = 12'd0;
          reg_plan[CFG_REQUIRE_LINK]    = 12'd1;
        end
        default: begin
          reg_plan[CFG_THERMAL_LIMIT]   = 12'($urandom_range(200, 3000));
          reg_plan[CFG_BLUE_SECONDS]    = 12'($urandom_range(1, 60));
          reg_plan[CFG_RED_SECONDS]     = 12'($urandom_range(1, 60));
          reg_plan[CFG_IDLE_LIMIT]      = 12'($urandom_range(5, 300));
          reg_plan[CFG_WEAR_ON_FRAMES]  = 12'($urandom_range(0, 6));
          reg_plan[CFG_WEAR_OFF_FRAMES] = 12'($urandom_range(0, 6));
          reg_plan[CFG_LINK_FRAMES]     = 12'($urandom_range(0, 6));
          reg_plan[CFG_REQUIRE_LINK]    = 12'($urandom_range(0, 1));
        end
      endcase
      load_regs();
      calm = (run == 3);
      if (run == 2 || run == 6) squeeze_req = 1'b1;
      run_sent = 0;
      while (run_sent < RUN_ITEMS) begin
        if ($urandom_range(0, 9) < 7) begin
          run_session();
        end else begin
          repeat ($urandom_range(1, 8))
            send(shaped(3'($urandom_range(OP_SHORT_KEY, OP_RSVD_7))));
        end
      end
      settle();
    end
    calm = 1'b0;
    repeat (10) @(posedge clk);

    $display("tb: %0d events sent, %0d status transfers checked, %0d register settings",
             events_sent, sb.checked, settings);
    $display("tb: beeps progress/phase/end %0d/%0d/%0d, power-offs %0d, overheats %0d, holds %0d",
             sb.tones[BEEP_PROGRESS], sb.tones[BEEP_PHASE], sb.tones[BEEP_END],
             sb.power_offs, sb.trips, squeezes);
    if (sb.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: timeout with %0d status items outstanding", sb.pending());
    $display("tb: done, errors");
    $finish;
  end

endmodule

// ===== light_therapy_session_controller.f =====
+incdir+rtl/core
rtl/core/ltsc_pkg.sv
rtl/core/light_therapy_session_controller.sv
rtl/core/ltsc_checker.sv
bench/tb.sv
